FILE: hdl/mcfe_pkg.sv
`default_nettype none

package mcfe_pkg;

  // step counter width, enough for the whole control store
  localparam int PC_W = 7;

  // command opcodes
  localparam logic [3:0] OP_WR_SINGLE = 4'd0;
  localparam logic [3:0] OP_EN        = 4'd1;
  localparam logic [3:0] OP_VEL       = 4'd2;
  localparam logic [3:0] OP_POS       = 4'd3;
  localparam logic [3:0] OP_FAST_CFG  = 4'd4;
  localparam logic [3:0] OP_FAST_MOVE = 4'd5;
  localparam logic [3:0] OP_X_EN      = 4'd6;
  localparam logic [3:0] OP_X_VEL     = 4'd7;
  localparam logic [3:0] OP_X_POS     = 4'd8;
  localparam logic [3:0] OP_STOP      = 4'd9;
  localparam logic [3:0] OP_SYNC_RUN  = 4'd10;

  // shared tails and program entry points
  localparam logic [PC_W-1:0] PC_TAIL_SY   = 7'd0;
  localparam logic [PC_W-1:0] PC_TAIL_CRC  = 7'd2;
  localparam logic [PC_W-1:0] PC_WR_SINGLE = 7'd4;
  localparam logic [PC_W-1:0] PC_EN        = 7'd10;
  localparam logic [PC_W-1:0] PC_VEL       = 7'd14;
  localparam logic [PC_W-1:0] PC_POS       = 7'd20;
  localparam logic [PC_W-1:0] PC_FAST_CFG  = 7'd31;
  localparam logic [PC_W-1:0] PC_FAST_MOVE = 7'd37;
  localparam logic [PC_W-1:0] PC_STOP      = 7'd44;
  localparam logic [PC_W-1:0] PC_SYNC_RUN  = 7'd47;
  localparam logic [PC_W-1:0] PC_X_EN      = 7'd51;
  localparam logic [PC_W-1:0] PC_X_VEL     = 7'd62;
  localparam logic [PC_W-1:0] PC_X_POS     = 7'd77;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // byte source select of one control word
  typedef enum logic [4:0] {
    SRC_K,
    SRC_ADDR,
    SRC_REG_HI,
    SRC_REG_LO,
    SRC_VAL_HI,
    SRC_VAL_LO,
    SRC_EN,
    SRC_SY,
    SRC_DIR,
    SRC_SPD_HI,
    SRC_SPD_LO,
    SRC_ACC_HI,
    SRC_ACC_LO,
    SRC_D3,
    SRC_D2,
    SRC_D1,
    SRC_D0,
    SRC_MODE,
    SRC_CRC_LO,
    SRC_CRC_HI
  } src_t;

  typedef struct packed {
    src_t            src;
    logic [7:0]      konst;
    logic            last;
    logic            jmp;
    logic [PC_W-1:0] target;
  } ctl_t;

  typedef struct packed {
    logic            known;
    logic [PC_W-1:0] pc;
  } entry_t;

  function automatic ctl_t cw_src(src_t s);
    ctl_t w;
    w = '{src: s, konst: 8'h00, last: 1'b0, jmp: 1'b0, target: '0};
    return w;
  endfunction

  function automatic ctl_t cw_src_jmp(src_t s, logic [PC_W-1:0] t);
    ctl_t w;
    w = '{src: s, konst: 8'h00, last: 1'b0, jmp: 1'b1, target: t};
    return w;
  endfunction

  function automatic ctl_t cw_src_last(src_t s);
    ctl_t w;
    w = '{src: s, konst: 8'h00, last: 1'b1, jmp: 1'b0, target: '0};
    return w;
  endfunction

  function automatic ctl_t cw_k(logic [7:0] k);
    ctl_t w;
    w = '{src: SRC_K, konst: k, last: 1'b0, jmp: 1'b0, target: '0};
    return w;
  endfunction

  function automatic ctl_t cw_k_jmp(logic [7:0] k, logic [PC_W-1:0] t);
    ctl_t w;
    w = '{src: SRC_K, konst: k, last: 1'b0, jmp: 1'b1, target: t};
    return w;
  endfunction

  function automatic ctl_t cw_k_last(logic [7:0] k);
    ctl_t w;
    w = '{src: SRC_K, konst: k, last: 1'b1, jmp: 1'b0, target: '0};
    return w;
  endfunction

  // opcode dispatch
  function automatic entry_t entry_of(logic [3:0] op);
    entry_t e;
    e.known = 1'b1;
    case (op)
      OP_WR_SINGLE: e.pc = PC_WR_SINGLE;
      OP_EN:        e.pc = PC_EN;
      OP_VEL:       e.pc = PC_VEL;
      OP_POS:       e.pc = PC_POS;
      OP_FAST_CFG:  e.pc = PC_FAST_CFG;
      OP_FAST_MOVE: e.pc = PC_FAST_MOVE;
      OP_X_EN:      e.pc = PC_X_EN;
      OP_X_VEL:     e.pc = PC_X_VEL;
      OP_X_POS:     e.pc = PC_X_POS;
      OP_STOP:      e.pc = PC_STOP;
      OP_SYNC_RUN:  e.pc = PC_SYNC_RUN;
      default: begin
        e.known = 1'b0;
        e.pc    = '0;
      end
    endcase
    return e;
  endfunction

  // control store
  function automatic ctl_t ucode(logic [PC_W-1:0] pc);
    ctl_t w;
    case (pc)
      // tail: sync flag then end byte
      7'd0:  w = cw_src(SRC_SY);
      7'd1:  w = cw_k_last(8'h6B);
      // tail: crc low then high
      7'd2:  w = cw_src(SRC_CRC_LO);
      7'd3:  w = cw_src_last(SRC_CRC_HI);
      // write single register
      7'd4:  w = cw_src(SRC_ADDR);
      7'd5:  w = cw_k(8'h06);
      7'd6:  w = cw_src(SRC_REG_HI);
      7'd7:  w = cw_src(SRC_REG_LO);
      7'd8:  w = cw_src(SRC_VAL_HI);
      7'd9:  w = cw_src_jmp(SRC_VAL_LO, PC_TAIL_CRC);
      // enable
      7'd10: w = cw_src(SRC_ADDR);
      7'd11: w = cw_k(8'hF3);
      7'd12: w = cw_k(8'hAB);
      7'd13: w = cw_src_jmp(SRC_EN, PC_TAIL_SY);
      // velocity
      7'd14: w = cw_src(SRC_ADDR);
      7'd15: w = cw_k(8'hF6);
      7'd16: w = cw_src(SRC_DIR);
      7'd17: w = cw_src(SRC_SPD_HI);
      7'd18: w = cw_src(SRC_SPD_LO);
      7'd19: w = cw_src_jmp(SRC_ACC_LO, PC_TAIL_SY);
      // position
      7'd20: w = cw_src(SRC_ADDR);
      7'd21: w = cw_k(8'hFD);
      7'd22: w = cw_src(SRC_DIR);
      7'd23: w = cw_src(SRC_SPD_HI);
      7'd24: w = cw_src(SRC_SPD_LO);
      7'd25: w = cw_src(SRC_ACC_LO);
      7'd26: w = cw_src(SRC_D3);
      7'd27: w = cw_src(SRC_D2);
      7'd28: w = cw_src(SRC_D1);
      7'd29: w = cw_src(SRC_D0);
      7'd30: w = cw_src_jmp(SRC_MODE, PC_TAIL_SY);
      // fast config
      7'd31: w = cw_src(SRC_ADDR);
      7'd32: w = cw_k(8'hF1);
      7'd33: w = cw_src(SRC_SPD_HI);
      7'd34: w = cw_src(SRC_SPD_LO);
      7'd35: w = cw_src(SRC_ACC_LO);
      7'd36: w = cw_src_jmp(SRC_MODE, PC_TAIL_SY);
      // fast move
      7'd37: w = cw_src(SRC_ADDR);
      7'd38: w = cw_k(8'hFC);
      7'd39: w = cw_src(SRC_D3);
      7'd40: w = cw_src(SRC_D2);
      7'd41: w = cw_src(SRC_D1);
      7'd42: w = cw_src(SRC_D0);
      7'd43: w = cw_k_last(8'h6B);
      // stop
      7'd44: w = cw_src(SRC_ADDR);
      7'd45: w = cw_k(8'hFE);
      7'd46: w = cw_k_jmp(8'h98, PC_TAIL_SY);
      // sync run
      7'd47: w = cw_src(SRC_ADDR);
      7'd48: w = cw_k(8'hFF);
      7'd49: w = cw_k(8'h66);
      7'd50: w = cw_k_last(8'h6B);
      // write multiple: enable
      7'd51: w = cw_src(SRC_ADDR);
      7'd52: w = cw_k(8'h10);
      7'd53: w = cw_k(8'h00);
      7'd54: w = cw_k(8'hE0);
      7'd55: w = cw_k(8'h00);
      7'd56: w = cw_k(8'h02);
      7'd57: w = cw_k(8'h04);
      7'd58: w = cw_k(8'hAB);
      7'd59: w = cw_src(SRC_EN);
      7'd60: w = cw_src(SRC_SY);
      7'd61: w = cw_k_jmp(8'h00, PC_TAIL_CRC);
      // write multiple: velocity
      7'd62: w = cw_src(SRC_ADDR);
      7'd63: w = cw_k(8'h10);
      7'd64: w = cw_k(8'h00);
      7'd65: w = cw_k(8'hE6);
      7'd66: w = cw_k(8'h00);
      7'd67: w = cw_k(8'h04);
      7'd68: w = cw_k(8'h08);
      7'd69: w = cw_src(SRC_DIR);
      7'd70: w = cw_k(8'h00);
      7'd71: w = cw_src(SRC_ACC_HI);
      7'd72: w = cw_src(SRC_ACC_LO);
      7'd73: w = cw_src(SRC_SPD_HI);
      7'd74: w = cw_src(SRC_SPD_LO);
      7'd75: w = cw_src(SRC_SY);
      7'd76: w = cw_k_jmp(8'h00, PC_TAIL_CRC);
      // write multiple: position
      7'd77: w = cw_src(SRC_ADDR);
      7'd78: w = cw_k(8'h10);
      7'd79: w = cw_k(8'h00);
      7'd80: w = cw_k(8'hF0);
      7'd81: w = cw_k(8'h00);
      7'd82: w = cw_k(8'h05);
      7'd83: w = cw_k(8'h0A);
      7'd84: w = cw_src(SRC_DIR);
      7'd85: w = cw_k(8'h00);
      7'd86: w = cw_src(SRC_SPD_HI);
      7'd87: w = cw_src(SRC_SPD_LO);
      7'd88: w = cw_src(SRC_D3);
      7'd89: w = cw_src(SRC_D2);
      7'd90: w = cw_src(SRC_D1);
      7'd91: w = cw_src(SRC_D0);
      7'd92: w = cw_src(SRC_MODE);
      7'd93: w = cw_src_jmp(SRC_SY, PC_TAIL_CRC);
      default: w = cw_k_last(8'h00);
    endcase
    return w;
  endfunction

  // modbus crc16 over one byte, reflected
  function automatic logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/mcfe_if.sv
`default_nettype none

// command channel
interface mcfe_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [7:0]  dest_address;
  logic        enable_flag;
  logic        sync_flag;
  logic [7:0]  direction;
  logic [15:0] speed;
  logic [15:0] accel;
  logic [31:0] distance;
  logic [7:0]  pos_mode;
  logic [15:0] reg_number;
  logic [15:0] reg_value;

  modport source (
    output valid, opcode, dest_address, enable_flag, sync_flag, direction,
           speed, accel, distance, pos_mode, reg_number, reg_value,
    input  ready
  );
  modport sink (
    input  valid, opcode, dest_address, enable_flag, sync_flag, direction,
           speed, accel, distance, pos_mode, reg_number, reg_value,
    output ready
  );
endinterface

// frame byte channel
interface mcfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface

`default_nettype wire

FILE: hdl/motor_command_frame_encoder.sv
`default_nettype none

// Motor command frame encoder. One command item in, its serial frame out one
// byte item per cycle while the sink is ready, last_byte marking the final
// byte. A short control program steps through the frame: a dispatch on the
// opcode picks the entry step, each control word selects one byte and the
// step counter advances, jumps into a shared tail (sync flag plus end byte,
// or the two crc bytes) or ends the frame itself. The crc16 is folded in
// byte by byte as the frame goes out. A frame of N bytes (4 to 19) occupies
// the block from acceptance until the one-step-per-cycle sequencer has put
// its last byte into the single output register; sink stalls stretch it.
// Unknown opcodes (11 to 15) are accepted without making the block busy and
// produce no bytes. No configuration, no state between commands.
module motor_command_frame_encoder (
  input  wire logic   clk,
  input  wire logic   rst_n,
  mcfe_in_if.sink     in_chan,
  mcfe_out_if.source  out_chan
);

  logic                          busy_r, busy_nxt;
  logic [mcfe_pkg::PC_W-1:0]     pc_r, pc_nxt;
  logic [15:0]                   crc_r, crc_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [7:0]                    out_byte_r, out_byte_nxt;
  logic                          out_last_r, out_last_nxt;

  // captured command
  logic [7:0]  addr_r;
  logic        en_r;
  logic        sy_r;
  logic [7:0]  dir_r;
  logic [15:0] spd_r;
  logic [15:0] acc_r;
  logic [31:0] dist_r;
  logic [7:0]  mode_r;
  logic [15:0] reg_num_r;
  logic [15:0] reg_val_r;

  mcfe_pkg::ctl_t   cw;
  mcfe_pkg::entry_t entry;
  logic [7:0]       byte_sel;
  logic             accept;
  logic             advance;
  logic             crc_upd;

  assign in_chan.ready      = !busy_r;
  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_byte  = out_byte_r;
  assign out_chan.last_byte = out_last_r;

  assign accept  = in_chan.valid && !busy_r;
  assign advance = busy_r && (!out_valid_r || out_chan.ready);
  assign cw      = mcfe_pkg::ucode(pc_r);
  assign entry   = mcfe_pkg::entry_of(in_chan.opcode);
  assign crc_upd = (cw.src != mcfe_pkg::SRC_CRC_LO) && (cw.src != mcfe_pkg::SRC_CRC_HI);

  // byte select datapath
  always_comb begin
    case (cw.src)
      mcfe_pkg::SRC_K:      byte_sel = cw.konst;
      mcfe_pkg::SRC_ADDR:   byte_sel = addr_r;
      mcfe_pkg::SRC_REG_HI: byte_sel = reg_num_r[15:8];
      mcfe_pkg::SRC_REG_LO: byte_sel = reg_num_r[7:0];
      mcfe_pkg::SRC_VAL_HI: byte_sel = reg_val_r[15:8];
      mcfe_pkg::SRC_VAL_LO: byte_sel = reg_val_r[7:0];
      mcfe_pkg::SRC_EN:     byte_sel = {7'b0, en_r};
      mcfe_pkg::SRC_SY:     byte_sel = {7'b0, sy_r};
      mcfe_pkg::SRC_DIR:    byte_sel = dir_r;
      mcfe_pkg::SRC_SPD_HI: byte_sel = spd_r[15:8];
      mcfe_pkg::SRC_SPD_LO: byte_sel = spd_r[7:0];
      mcfe_pkg::SRC_ACC_HI: byte_sel = acc_r[15:8];
      mcfe_pkg::SRC_ACC_LO: byte_sel = acc_r[7:0];
      mcfe_pkg::SRC_D3:     byte_sel = dist_r[31:24];
      mcfe_pkg::SRC_D2:     byte_sel = dist_r[23:16];
      mcfe_pkg::SRC_D1:     byte_sel = dist_r[15:8];
      mcfe_pkg::SRC_D0:     byte_sel = dist_r[7:0];
      mcfe_pkg::SRC_MODE:   byte_sel = mode_r;
      mcfe_pkg::SRC_CRC_LO: byte_sel = crc_r[7:0];
      mcfe_pkg::SRC_CRC_HI: byte_sel = crc_r[15:8];
      default:              byte_sel = 8'h00;
    endcase
  end

  // sequencer next state
  always_comb begin
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      busy_nxt = entry.known;
      pc_nxt   = entry.pc;
      crc_nxt  = mcfe_pkg::CRC_INIT;
    end else if (advance) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = byte_sel;
      out_last_nxt  = cw.last;
      if (crc_upd) begin
        crc_nxt = mcfe_pkg::crc_byte(crc_r, byte_sel);
      end
      if (cw.jmp) begin
        pc_nxt = cw.target;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
      if (cw.last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // control state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      pc_r        <= pc_nxt;
    end
    crc_r      <= crc_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  // command capture
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r    <= in_chan.dest_address;
      en_r      <= in_chan.enable_flag;
      sy_r      <= in_chan.sync_flag;
      dir_r     <= in_chan.direction;
      spd_r     <= in_chan.speed;
      acc_r     <= in_chan.accel;
      dist_r    <= in_chan.distance;
      mode_r    <= in_chan.pos_mode;
      reg_num_r <= in_chan.reg_number;
      reg_val_r <= in_chan.reg_value;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mcfe_checker.sv
`default_nettype none

module mcfe_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [3:0] in_opcode,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       last_byte
);

  // stalled byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_byte))
    else $error("frame byte changed while stalled");

  // no new command while a frame is only partly out
  a_no_accept_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last_byte |-> !in_ready)
    else $error("command taken in the middle of a frame");

  // a taken non-final byte is followed at once by the next one
  a_next_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_byte |=> out_valid)
    else $error("gap inside a frame");

  // unknown opcode leaves the block free
  a_unknown_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode > mcfe_pkg::OP_SYNC_RUN) |=> in_ready)
    else $error("unknown opcode started a frame");

endmodule

bind motor_command_frame_encoder mcfe_checker u_mcfe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_opcode (in_chan.opcode),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_byte  (out_chan.out_byte),
  .last_byte (out_chan.last_byte)
);

`default_nettype wire

FILE: verif/motor_command_frame_encoder_chk.sv
`timescale 1ns / 1ps

module motor_command_frame_encoder_chk (
  input  wire logic clk,
  mcfe_in_if        in_mon,
  mcfe_out_if       out_mon,
  output int        mismatch_count,
  output int        bytes_pending
);

  localparam int FRAME_MAX  = 19;
  localparam int PRINT_CAP  = 100;

  // modbus function codes and register starts
  localparam logic [7:0]  FN_WRITE_SINGLE = 8'h06;
  localparam logic [7:0]  FN_WRITE_MULTI  = 8'h10;
  localparam logic [15:0] REG_X_EN        = 16'h00E0;
  localparam logic [15:0] REG_X_VEL       = 16'h00E6;
  localparam logic [15:0] REG_X_POS       = 16'h00F0;

  // simple protocol command bytes, keys and frame end
  localparam logic [7:0] CMD_EN        = 8'hF3;
  localparam logic [7:0] CMD_VEL       = 8'hF6;
  localparam logic [7:0] CMD_POS       = 8'hFD;
  localparam logic [7:0] CMD_FAST_CFG  = 8'hF1;
  localparam logic [7:0] CMD_FAST_MOVE = 8'hFC;
  localparam logic [7:0] CMD_STOP      = 8'hFE;
  localparam logic [7:0] CMD_SYNC_RUN  = 8'hFF;
  localparam logic [7:0] EN_KEY        = 8'hAB;
  localparam logic [7:0] STOP_KEY      = 8'h98;
  localparam logic [7:0] SYNC_KEY      = 8'h66;
  localparam logic [7:0] FRAME_END     = 8'h6B;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  frame_byte_t expected_frame_q[$];
  logic [7:0]  frame_buf[FRAME_MAX];
  int          frame_len;

  initial begin
    mismatch_count = 0;
    bytes_pending  = 0;
    frame_len      = 0;
  end

  function automatic void append_byte(input logic [7:0] b);
    frame_buf[frame_len] = b;
    frame_len++;
  endfunction

  function automatic void append_word(input logic [15:0] w);
    append_byte(w[15:8]);
    append_byte(w[7:0]);
  endfunction

  // reflected crc16 over the frame so far, low byte goes out first
  function automatic void append_crc();
    logic [15:0] crc;
    crc = mcfe_pkg::CRC_INIT;
    for (int i = 0; i < frame_len; i++) begin
      crc = crc ^ {8'h00, frame_buf[i]};
      repeat (8) begin
        crc = crc[0] ? ((crc >> 1) ^ mcfe_pkg::CRC_POLY) : (crc >> 1);
      end
    end
    append_byte(crc[7:0]);
    append_byte(crc[15:8]);
  endfunction

  function automatic void append_multi_header(input logic [7:0] addr,
                                              input logic [15:0] start,
                                              input logic [7:0] words);
    append_byte(addr);
    append_byte(FN_WRITE_MULTI);
    append_word(start);
    append_byte(8'h00);
    append_byte(words);
    append_byte({words[6:0], 1'b0});
  endfunction

  // build the frame for the command on the input channel and queue its bytes
  function automatic void encode_command();
    logic [7:0]  addr;
    logic [7:0]  en_b;
    logic [7:0]  sy_b;
    logic [15:0] sy_word;
    addr    = in_mon.dest_address;
    en_b    = {7'b0, in_mon.enable_flag};
    sy_b    = {7'b0, in_mon.sync_flag};
    sy_word = in_mon.sync_flag ? 16'h0100 : 16'h0000;
    frame_len = 0;
    case (in_mon.opcode)
      mcfe_pkg::OP_WR_SINGLE: begin
        append_byte(addr);
        append_byte(FN_WRITE_SINGLE);
        append_word(in_mon.reg_number);
        append_word(in_mon.reg_value);
        append_crc();
      end
      mcfe_pkg::OP_EN: begin
        append_byte(addr);
        append_byte(CMD_EN);
        append_byte(EN_KEY);
        append_byte(en_b);
        append_byte(sy_b);
        append_byte(FRAME_END);
      end
      mcfe_pkg::OP_VEL: begin
        append_byte(addr);
        append_byte(CMD_VEL);
        append_byte(in_mon.direction);
        append_word(in_mon.speed);
        append_byte(in_mon.accel[7:0]);
        append_byte(sy_b);
        append_byte(FRAME_END);
      end
      mcfe_pkg::OP_POS: begin
        append_byte(addr);
        append_byte(CMD_POS);
        append_byte(in_mon.direction);
        append_word(in_mon.speed);
        append_byte(in_mon.accel[7:0]);
        append_word(in_mon.distance[31:16]);
        append_word(in_mon.distance[15:0]);
        append_byte(in_mon.pos_mode);
        append_byte(sy_b);
        append_byte(FRAME_END);
      end
      mcfe_pkg::OP_FAST_CFG: begin
        append_byte(addr);
        append_byte(CMD_FAST_CFG);
        append_word(in_mon.speed);
        append_byte(in_mon.accel[7:0]);
        append_byte(in_mon.pos_mode);
        append_byte(sy_b);
        append_byte(FRAME_END);
      end
      mcfe_pkg::OP_FAST_MOVE: begin
        append_byte(addr);
        append_byte(CMD_FAST_MOVE);
        append_word(in_mon.distance[31:16]);
        append_word(in_mon.distance[15:0]);
        append_byte(FRAME_END);
      end
      mcfe_pkg::OP_X_EN: begin
        append_multi_header(addr, REG_X_EN, 8'd2);
        append_word({EN_KEY, en_b});
        append_word(sy_word);
        append_crc();
      end
      mcfe_pkg::OP_X_VEL: begin
        append_multi_header(addr, REG_X_VEL, 8'd4);
        append_word({in_mon.direction, 8'h00});
        append_word(in_mon.accel);
        append_word(in_mon.speed);
        append_word(sy_word);
        append_crc();
      end
      mcfe_pkg::OP_X_POS: begin
        append_multi_header(addr, REG_X_POS, 8'd5);
        append_word({in_mon.direction, 8'h00});
        append_word(in_mon.speed);
        append_word(in_mon.distance[31:16]);
        append_word(in_mon.distance[15:0]);
        append_word({in_mon.pos_mode, sy_b});
        append_crc();
      end
      mcfe_pkg::OP_STOP: begin
        append_byte(addr);
        append_byte(CMD_STOP);
        append_byte(STOP_KEY);
        append_byte(sy_b);
        append_byte(FRAME_END);
      end
      mcfe_pkg::OP_SYNC_RUN: begin
        append_byte(addr);
        append_byte(CMD_SYNC_RUN);
        append_byte(SYNC_KEY);
        append_byte(FRAME_END);
      end
      // unknown opcodes send nothing
      default: ;
    endcase
    for (int k = 0; k < frame_len; k++) begin
      expected_frame_q.push_back('{data: frame_buf[k], last: (k == frame_len - 1)});
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // compare one frame byte item with the oldest expected byte
  task automatic check_frame_byte();
    frame_byte_t want;
    if (expected_frame_q.size() == 0) begin
      report_mismatch($sformatf("unexpected byte %02h last %0b",
                                out_mon.out_byte, out_mon.last_byte));
    end else begin
      want = expected_frame_q.pop_front();
      if (out_mon.out_byte !== want.data) begin
        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                  out_mon.out_byte, want.data));
      end
      if (out_mon.last_byte !== want.last) begin
        report_mismatch($sformatf("last_byte %0b, expected %0b (byte %02h)",
                                  out_mon.last_byte, want.last, want.data));
      end
    end
  endtask

  // watch both channels at the rising edge
  always @(posedge clk) begin
    if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
      encode_command();
    end
    if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
      check_frame_byte();
    end
    bytes_pending = expected_frame_q.size();
  end

endmodule

FILE: verif/motor_command_frame_encoder_tb.sv
`timescale 1ns / 1ps

module motor_command_frame_encoder_tb;

  localparam int         RANDOM_ITEMS    = 300;
  localparam int         HOLD_OFF_CYCLES = 250;
  localparam int         WATCHDOG_LIMIT  = 2000;
  localparam int         SETTLE_CYCLES   = 40;
  localparam logic [3:0] OP_CODE_MAX     = 4'hF;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [7:0]  dest_address;
    logic        enable_flag;
    logic        sync_flag;
    logic [7:0]  direction;
    logic [15:0] speed;
    logic [15:0] accel;
    logic [31:0] distance;
    logic [7:0]  pos_mode;
    logic [15:0] reg_number;
    logic [15:0] reg_value;
  } motor_cmd_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_pattern_t;

  logic clk           = 1'b0;
  logic rst_n         = 1'b0;
  logic hold_off_req  = 1'b0;
  logic hold_off_done = 1'b0;
  int   mismatch_count;
  int   bytes_pending;

  mcfe_in_if  in_chan ();
  mcfe_out_if out_chan ();

  motor_command_frame_encoder u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  motor_command_frame_encoder_chk u_chk (
    .clk            (clk),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .mismatch_count (mismatch_count),
    .bytes_pending  (bytes_pending)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // field value biased toward the extremes
  function automatic logic [31:0] field_value(input int width);
    logic [31:0] ones;
    ones = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return ones;
      default: return $urandom() & ones;
    endcase
  endfunction

  function automatic motor_cmd_t random_cmd(input logic [3:0] op);
    motor_cmd_t c;
    c.opcode       = op;
    c.dest_address = 8'(field_value(8));
    c.enable_flag  = 1'(field_value(1));
    c.sync_flag    = 1'(field_value(1));
    c.direction    = 8'(field_value(8));
    c.speed        = 16'(field_value(16));
    c.accel        = 16'(field_value(16));
    c.distance     = field_value(32);
    c.pos_mode     = 8'(field_value(8));
    c.reg_number   = 16'(field_value(16));
    c.reg_value    = 16'(field_value(16));
    return c;
  endfunction

  // every field but the opcode all zeros or all ones
  function automatic motor_cmd_t uniform_cmd(input logic [3:0] op, input logic fill);
    motor_cmd_t c;
    c        = {$bits(motor_cmd_t){fill}};
    c.opcode = op;
    return c;
  endfunction

  // mostly known opcodes, now and then an unknown one
  function automatic logic [3:0] pick_opcode();
    if ($urandom_range(0, 15) == 0) begin
      return 4'($urandom_range(OP_CODE_MAX, mcfe_pkg::OP_SYNC_RUN + 1));
    end
    return 4'($urandom_range(mcfe_pkg::OP_SYNC_RUN, mcfe_pkg::OP_WR_SINGLE));
  endfunction

  task automatic present_cmd(input motor_cmd_t c);
    in_chan.opcode       = c.opcode;
    in_chan.dest_address = c.dest_address;
    in_chan.enable_flag  = c.enable_flag;
    in_chan.sync_flag    = c.sync_flag;
    in_chan.direction    = c.direction;
    in_chan.speed        = c.speed;
    in_chan.accel        = c.accel;
    in_chan.distance     = c.distance;
    in_chan.pos_mode     = c.pos_mode;
    in_chan.reg_number   = c.reg_number;
    in_chan.reg_value    = c.reg_value;
  endtask

  // offer one command item at the falling edge, return at the falling edge after acceptance
  task automatic send_cmd(input motor_cmd_t c);
    present_cmd(c);
    in_chan.valid = 1'b1;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  // stop offering until every expected byte is out, then let the block settle
  task automatic wait_frames_done();
    in_chan.valid = 1'b0;
    while (bytes_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // receiver: changing ready patterns, plus one long hold-off on request
  initial begin
    rx_pattern_t pattern;
    int          seg_left;
    int          hold_cnt;
    out_chan.ready = 1'b0;
    pattern        = RX_OPEN;
    seg_left       = 0;
    hold_cnt       = 0;
    forever begin
      @(negedge clk);
      if (seg_left == 0) begin
        pattern  = rx_pattern_t'($urandom_range(0, 3));
        seg_left = $urandom_range(16, 96);
      end
      seg_left--;
      if (hold_off_req && !hold_off_done) begin
        out_chan.ready = 1'b0;
        hold_cnt++;
        if (hold_cnt >= HOLD_OFF_CYCLES) hold_off_done = 1'b1;
      end else begin
        case (pattern)
          RX_OPEN:   out_chan.ready = 1'b1;
          RX_COIN:   out_chan.ready = ($urandom_range(0, 1) == 0);
          RX_SPARSE: out_chan.ready = ($urandom_range(0, 3) == 0);
          default:   out_chan.ready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // watchdog on cycles with no item moving on either channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
          (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  // stimulus and verdict
  initial begin
    motor_cmd_t cmd;
    int         known_sent;
    int         burst;
    logic       paused;
    in_chan.valid = 1'b0;
    present_cmd(uniform_cmd(mcfe_pkg::OP_WR_SINGLE, 1'b0));
    known_sent = 0;
    paused     = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed: every known opcode with all fields low and all fields high
    for (int op = mcfe_pkg::OP_WR_SINGLE; op <= mcfe_pkg::OP_SYNC_RUN; op++) begin
      send_cmd(uniform_cmd(4'(op), 1'b0));
      send_cmd(uniform_cmd(4'(op), 1'b1));
    end
    // unknown opcodes at both ends of the unused range
    send_cmd(uniform_cmd(4'(mcfe_pkg::OP_SYNC_RUN + 1), 1'b1));
    send_cmd(uniform_cmd(OP_CODE_MAX, 1'b0));
    wait_frames_done();

    // random bursts of commands with random gaps
    while (known_sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        cmd = random_cmd(pick_opcode());
        send_cmd(cmd);
        if (cmd.opcode <= mcfe_pkg::OP_SYNC_RUN) known_sent++;
      end
      if (known_sent >= RANDOM_ITEMS / 3 && !hold_off_req) begin
        // long receiver hold-off while long frames keep coming
        hold_off_req = 1'b1;
        repeat (12) send_cmd(random_cmd(mcfe_pkg::OP_X_POS));
        in_chan.valid = 1'b0;
        while (!hold_off_done) @(negedge clk);
      end else if (known_sent >= 2 * RANDOM_ITEMS / 3 && !paused) begin
        paused = 1'b1;
        wait_frames_done();
      end else if ($urandom_range(0, 3) != 0) begin
        in_chan.valid = 1'b0;
        present_cmd(random_cmd(pick_opcode()));
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end

    wait_frames_done();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/mcfe_pkg.sv
hdl/mcfe_if.sv
hdl/motor_command_frame_encoder.sv
hdl/mcfe_checker.sv
verif/motor_command_frame_encoder_chk.sv
verif/motor_command_frame_encoder_tb.sv
